### hdl/midi_events_to_psg_commands_core_defines.svh
// Assertion macros shared by the checker of the event-to-command core.
// No dependencies; included by the checker file.
`ifndef MIDI_EVENTS_TO_PSG_COMMANDS_CORE_DEFINES_SVH
`define MIDI_EVENTS_TO_PSG_COMMANDS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MEPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MEPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mepc_pkg.sv
// Shared types, constants and helper functions of the event-to-command core.
// No dependencies.
package mepc_pkg;

    localparam logic [7:0]  END_MARK         = 8'hFC;
    localparam logic [3:0]  CMD_NOTE_OFF     = 4'h8;
    localparam logic [3:0]  CMD_NOTE_ON      = 4'h9;
    localparam logic [3:0]  CMD_CONTROL      = 4'hB;
    localparam logic [7:0]  CC_SOUND_OFF     = 8'h78;
    localparam logic [7:0]  CC_NOTES_OFF     = 8'h7B;
    localparam logic [16:0] TONE_CLK_DIV32   = 17'd111860;
    localparam logic [3:0]  ATT_VOICE0       = 4'd0;
    localparam logic [3:0]  ATT_NOISE        = 4'd10;
    localparam logic [3:0]  ATT_TONE         = 4'd7;
    localparam logic [3:0]  ATT_SILENT       = 4'd15;
    localparam logic [5:0]  NOISE_TONE_HIGH  = 6'd5;
    localparam logic [3:0]  NOISE_TONE_LOW   = 4'd5;
    localparam logic [15:0] TERM_DURATION    = 16'hFFFF;
    localparam logic [15:0] BORROW_MAX       = 16'hFFFF;

    localparam logic [15:0] TONE_TABLE [12] = '{
        16'd28160, 16'd29834, 16'd31608, 16'd33488, 16'd35479, 16'd37589,
        16'd39824, 16'd42192, 16'd44701, 16'd47359, 16'd50175, 16'd53159
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CALC,
        ST_DIV,
        ST_COMMIT,
        ST_FL_PEND,
        ST_FL_TERM
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take;
        logic       decode;
        logic       calc;
        logic       div_go;
        logic       commit;
        logic       emit_pend;
        logic       emit_term;
        logic       mark_last;
        logic [1:0] fl_voice;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_end;
        logic act;
        logic need_emit;
        logic div_idle;
        logic fl_pend;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [15:0] dur;
        logic [5:0]  th;
        logic [3:0]  tl;
        logic [3:0]  att;
    } t_pend;

    // Frequency in Hz of a note number; note 0 is silence.
    function automatic logic [15:0] note_hz(input logic [7:0] note);
        logic [8:0]  a;
        logic [16:0] pa;
        logic [4:0]  qa;
        logic [3:0]  idx;
        logic [7:0]  s;
        logic [16:0] ps;
        logic [4:0]  q;
        logic [3:0]  sh;
        a   = {1'b0, note} + 9'd3;
        pa  = 17'(a) * 17'd171;
        qa  = pa[15:11];
        idx = 4'(a - 9'(qa) * 9'd12);
        s   = (note >= 8'd9) ? (note - 8'd9) : 8'd0;
        ps  = 17'(s) * 17'd171;
        q   = ps[15:11];
        sh  = (q >= 5'd10) ? 4'd0 : 4'(5'd10 - q);
        if (note == 8'd0) begin
            return 16'd0;
        end
        return TONE_TABLE[idx] >> sh;
    endfunction

    // Shift the raw quotient right until it fits in ten bits.
    function automatic logic [9:0] norm_div(input logic [16:0] q);
        logic [9:0] d;
        d = q[9:0];
        for (int k = 1; k <= 7; k++) begin
            if (q[9+k]) begin
                d = 10'(q >> k);
            end
        end
        return d;
    endfunction

endpackage

### hdl/mepc_div.sv
// Restoring divider, one quotient bit per cycle, for the tone divider.
// Depends on mepc_pkg for the dividend constant.
module mepc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic [16:0] o_quotient
);
    import mepc_pkg::*;

    logic [16:0] r_rem;
    logic [16:0] r_quo;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic [16:0] w;
    logic        ge;

    assign w  = {r_rem[15:0], r_quo[16]};
    assign ge = (w >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 5'd17;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= TONE_CLK_DIV32;
            r_dvs <= i_divisor;
        end else if (r_cnt != 5'd0) begin
            r_rem <= ge ? (w - {1'b0, r_dvs}) : w;
            r_quo <= {r_quo[15:0], ge};
        end
    end

    assign o_busy     = (r_cnt != 5'd0);
    assign o_quotient = r_quo;
endmodule

### hdl/mepc_ctrl.sv
// Controller state machine: sequences decode, period close, division and emission.
// Depends on mepc_pkg for the state, command and status types.
module mepc_ctrl #(
    parameter int VOICES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mepc_pkg::t_dp_sts i_sts,
    output mepc_pkg::t_dp_ctl o_ctl
);
    import mepc_pkg::*;

    localparam logic [1:0] LAST_VOICE = 2'(VOICES - 1);

    t_state     r_state, n_state;
    logic [1:0] r_fl, n_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fl    <= '0;
        end else begin
            r_state <= n_state;
            r_fl    <= n_fl;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fl       = r_fl;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        o_ctl.fl_voice = r_fl;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.take = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_ctl.decode = 1'b1;
                if (i_sts.is_end) begin
                    n_fl    = '0;
                    n_state = ST_FL_PEND;
                end else if (i_sts.act) begin
                    n_state = ST_CALC;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CALC: begin
                o_ctl.calc   = 1'b1;
                o_ctl.div_go = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_idle) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (!i_sts.need_emit || i_sts.out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_FL_PEND: begin
                if (!i_sts.fl_pend) begin
                    n_state = ST_FL_TERM;
                end else if (i_sts.out_free) begin
                    o_ctl.emit_pend = 1'b1;
                    n_state         = ST_FL_TERM;
                end
            end
            ST_FL_TERM: begin
                if (i_sts.out_free) begin
                    o_ctl.emit_term = 1'b1;
                    if (r_fl == LAST_VOICE) begin
                        o_ctl.mark_last = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        n_fl    = r_fl + 2'd1;
                        n_state = ST_FL_PEND;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

### hdl/mepc_dp.sv
// Datapath: event decode, per-channel and per-voice state, period arithmetic,
// pending commands and the output register. Depends on mepc_pkg and mepc_div.
module mepc_dp #(
    parameter int IN_CHANNELS = 16,
    parameter int VOICES      = 4,
    parameter int NOISE_VOICE = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mepc_pkg::t_dp_ctl i_ctl,
    output mepc_pkg::t_dp_sts o_sts,
    input  logic              i_cfg_wr,
    input  logic [63:0]       i_cfg_data,
    output logic [63:0]       o_channel_map,
    input  logic [7:0]        i_delta_ticks,
    input  logic [7:0]        i_event_byte,
    input  logic [7:0]        i_param1,
    input  logic [7:0]        i_param2,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_voice,
    output logic [15:0]       o_duration,
    output logic [5:0]        o_tone_high,
    output logic [3:0]        o_tone_low,
    output logic [3:0]        o_attenuation,
    output logic              o_terminator,
    output logic              o_last
);
    import mepc_pkg::*;

    localparam int CH_W    = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [1:0] NOISE_V = 2'(NOISE_VOICE);

    logic [63:0] r_channel_map;
    logic [7:0]  r_running;
    logic [31:0] r_song;
    logic [7:0]  r_delta, r_ev, r_p1, r_p2;
    logic [7:0]  r_held [IN_CHANNELS];
    logic [15:0] r_freq [VOICES];
    logic [31:0] r_last_ticks [VOICES];
    logic [15:0] r_borrowed [VOICES];
    logic        r_pv [VOICES];
    t_pend       r_pend [VOICES];
    logic [1:0]  r_voice;
    logic [15:0] r_newf;
    logic [15:0] r_c_dur;
    logic [3:0]  r_c_att;
    logic        r_old_nz;
    logic        r_need_emit;

    // Decode of the latched event.
    logic        is_end;
    logic [7:0]  ev_eff;
    logic [3:0]  ev_cmd, ev_ch;
    logic        ch_ok, v_ok;
    logic [3:0]  v_nib;
    logic [7:0]  held;
    logic        note_on, note_off, ctl_off, wants;
    logic [15:0] newf;

    assign is_end  = (r_delta == END_MARK) || (r_ev == END_MARK);
    assign ev_eff  = r_ev[7] ? r_ev : r_running;
    assign ev_cmd  = ev_eff[7:4];
    assign ev_ch   = ev_eff[3:0];
    assign ch_ok   = ({1'b0, ev_ch} < 5'(IN_CHANNELS));
    assign v_nib   = 4'(r_channel_map >> {ev_ch, 2'b00});
    assign v_ok    = ({1'b0, v_nib} < 5'(VOICES));
    assign held    = r_held[ev_ch[CH_W-1:0]];
    assign note_on = (ev_cmd == CMD_NOTE_ON) && (r_p2 != 8'd0);
    assign note_off = (((ev_cmd == CMD_NOTE_ON) && (r_p2 == 8'd0))
                      || (ev_cmd == CMD_NOTE_OFF)) && (held == r_p1);
    assign ctl_off = (ev_cmd == CMD_CONTROL)
                     && ((r_p1 == CC_NOTES_OFF) || (r_p1 == CC_SOUND_OFF));
    assign wants   = (note_on || note_off || ctl_off) && ch_ok && v_ok;
    assign newf    = note_on ? note_hz(r_p1) : 16'd0;

    // Period close arithmetic for the selected voice.
    logic [VOICE_W-1:0] vi;
    logic [31:0] elapsed;
    logic [32:0] t_full;
    logic        t_neg, t_zero, old_nz, replace;
    logic [15:0] b_new, c_dur;

    assign vi      = r_voice[VOICE_W-1:0];
    assign old_nz  = (r_freq[vi] != 16'd0);
    assign elapsed = r_song - r_last_ticks[vi];
    assign t_full  = {1'b0, elapsed} - {17'd0, r_borrowed[vi]};
    assign t_neg   = t_full[32];
    assign t_zero  = t_neg || (t_full[31:0] == 32'd0);

    always_comb begin
        b_new   = t_neg ? (r_borrowed[vi] - elapsed[15:0]) : 16'd0;
        c_dur   = t_neg ? 16'd0 : t_full[15:0];
        replace = 1'b0;
        if (t_zero && r_pv[vi]) begin
            if (old_nz) begin
                c_dur   = r_pend[vi].dur;
                replace = 1'b1;
            end else begin
                c_dur = 16'd1;
                if (b_new != BORROW_MAX) begin
                    b_new = b_new + 16'd1;
                end
            end
        end
    end

    // Tone divider of the old frequency.
    logic        div_busy;
    logic [16:0] div_q;
    logic [9:0]  div_d;

    mepc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_go && old_nz),
        .i_divisor  (r_freq[vi]),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign div_d = norm_div(div_q);

    // Command and flush voice selections.
    logic [VOICE_W-1:0] fi;
    t_pend emit_src;
    logic [1:0] emit_voice;
    assign fi         = i_ctl.fl_voice[VOICE_W-1:0];
    assign emit_voice = i_ctl.emit_pend ? i_ctl.fl_voice : r_voice;
    assign emit_src   = i_ctl.emit_pend ? r_pend[fi] : r_pend[vi];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_map <= '1;
            r_running     <= '0;
            r_song        <= '0;
            for (int c = 0; c < IN_CHANNELS; c++) begin
                r_held[c] <= '0;
            end
            for (int v = 0; v < VOICES; v++) begin
                r_freq[v]       <= '0;
                r_last_ticks[v] <= '0;
                r_borrowed[v]   <= '0;
                r_pv[v]         <= 1'b0;
            end
        end else begin
            if (i_cfg_wr) begin
                r_channel_map <= i_cfg_data;
            end
            if (i_ctl.take && (i_delta_ticks != END_MARK)) begin
                r_song <= r_song + 32'(i_delta_ticks);
            end
            if (i_ctl.decode && !is_end) begin
                r_running <= ev_eff;
                if (ch_ok && v_ok) begin
                    if (note_on) begin
                        r_held[ev_ch[CH_W-1:0]] <= r_p1;
                    end else if (note_off) begin
                        r_held[ev_ch[CH_W-1:0]] <= 8'd0;
                    end
                end
            end
            if (i_ctl.calc) begin
                r_borrowed[vi] <= b_new;
            end
            if (i_ctl.commit) begin
                r_pv[vi]         <= 1'b1;
                r_freq[vi]       <= r_newf;
                r_last_ticks[vi] <= r_song;
            end
            if (i_ctl.emit_pend) begin
                r_pv[fi] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_delta <= i_delta_ticks;
            r_ev    <= i_event_byte;
            r_p1    <= i_param1;
            r_p2    <= i_param2;
        end
        if (i_ctl.decode) begin
            r_voice <= v_nib[1:0];
            r_newf  <= newf;
        end
        if (i_ctl.calc) begin
            r_c_dur     <= c_dur;
            r_old_nz    <= old_nz;
            r_need_emit <= !replace && r_pv[vi];
            if (!old_nz) begin
                r_c_att <= ATT_SILENT;
            end else if (r_voice == 2'd0) begin
                r_c_att <= ATT_VOICE0;
            end else if (r_voice == NOISE_V) begin
                r_c_att <= ATT_NOISE;
            end else begin
                r_c_att <= ATT_TONE;
            end
        end
        if (i_ctl.commit) begin
            r_pend[vi].dur <= r_c_dur;
            r_pend[vi].th  <= r_old_nz ? div_d[9:4] : 6'd0;
            r_pend[vi].tl  <= r_old_nz ? div_d[3:0] : 4'd0;
            r_pend[vi].att <= r_c_att;
        end
    end

    // Output register.
    logic load_cmd;
    assign load_cmd = i_ctl.emit_pend || (i_ctl.commit && r_need_emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (load_cmd || i_ctl.emit_term) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_term) begin
            o_voice       <= i_ctl.fl_voice;
            o_duration    <= TERM_DURATION;
            o_tone_high   <= 6'd0;
            o_tone_low    <= 4'd0;
            o_attenuation <= 4'd0;
            o_terminator  <= 1'b1;
            o_last        <= i_ctl.mark_last;
        end else if (load_cmd) begin
            o_voice       <= emit_voice;
            o_duration    <= emit_src.dur;
            o_tone_high   <= (emit_voice == NOISE_V) ? NOISE_TONE_HIGH : emit_src.th;
            o_tone_low    <= (emit_voice == NOISE_V) ? NOISE_TONE_LOW : emit_src.tl;
            o_attenuation <= emit_src.att;
            o_terminator  <= 1'b0;
            o_last        <= i_ctl.commit;
        end
    end

    assign o_channel_map  = r_channel_map;
    assign o_sts.is_end    = is_end;
    assign o_sts.act       = wants && (newf != r_freq[v_nib[VOICE_W-1:0]]);
    assign o_sts.need_emit = r_need_emit;
    assign o_sts.div_idle  = !div_busy;
    assign o_sts.fl_pend   = r_pv[fi];
    assign o_sts.out_free  = !o_out_valid || i_out_ready;
endmodule

### hdl/midi_events_to_psg_commands_core.sv
// Top level of the event-to-command core: configuration port, controller and datapath.
// Depends on mepc_pkg, mepc_ctrl, mepc_dp and mepc_div.
//
//   Channel    Handshake                         Payload
//   input      i_in_valid / o_in_ready           delta_ticks, event_byte, param1, param2
//   output     o_out_valid / i_out_ready         voice, duration, tone_high, tone_low,
//                                                attenuation, terminator, last
//   config     psel, penable, pwrite, pready     paddr, pwdata, prdata (channel_map)
//
// Steps: a request that changes nothing is accepted and decoded; one that closes
// a period is accepted, decoded, then goes through the period arithmetic, the divide
// state and a commit, with no division when the voice was silent; an end request
// is accepted and decoded, then passes a pending and a terminator state per voice.
// Reset is synchronous, active low, with no clearing pass. A stalled output
// holds the controller in its emit state, and input is taken only in its idle state.
module midi_events_to_psg_commands_core #(
    parameter int IN_CHANNELS = 16,
    parameter int VOICES      = 4,
    parameter int NOISE_VOICE = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_delta_ticks,
    input  logic [7:0]  i_event_byte,
    input  logic [7:0]  i_param1,
    input  logic [7:0]  i_param2,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_voice,
    output logic [15:0] o_duration,
    output logic [5:0]  o_tone_high,
    output logic [3:0]  o_tone_low,
    output logic [3:0]  o_attenuation,
    output logic        o_terminator,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import mepc_pkg::*;

    t_dp_ctl     ctl;
    t_dp_sts     sts;
    logic        cfg_wr;
    logic [63:0] channel_map;

    // The only register, channel_map, sits at byte address 0; bit 3 of the
    // address selects anything beyond it, which reads as zero and ignores writes.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[3];
    assign prdata = paddr[3] ? 64'd0 : channel_map;

    // The controller decides what happens each cycle; the datapath holds all
    // of the song state and answers with a few status flags.
    mepc_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    mepc_dp #(
        .IN_CHANNELS (IN_CHANNELS),
        .VOICES      (VOICES),
        .NOISE_VOICE (NOISE_VOICE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cfg_wr      (cfg_wr),
        .i_cfg_data    (pwdata),
        .o_channel_map (channel_map),
        .i_delta_ticks (i_delta_ticks),
        .i_event_byte  (i_event_byte),
        .i_param1      (i_param1),
        .i_param2      (i_param2),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_voice       (o_voice),
        .o_duration    (o_duration),
        .o_tone_high   (o_tone_high),
        .o_tone_low    (o_tone_low),
        .o_attenuation (o_attenuation),
        .o_terminator  (o_terminator),
        .o_last        (o_last)
    );
endmodule

### hdl/mepc_chk.sv
// Port-level checker of the event-to-command core, bound to the top level.
// Depends on midi_events_to_psg_commands_core_defines.svh.
`include "midi_events_to_psg_commands_core_defines.svh"

module mepc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_voice,
    input logic [15:0] o_duration,
    input logic [5:0]  o_tone_high,
    input logic [3:0]  o_tone_low,
    input logic [3:0]  o_attenuation,
    input logic        o_terminator,
    input logic        o_last
);
    logic        out_stall;
    logic        in_take;
    logic        term_ok;
    logic [33:0] out_word;

    assign out_stall = o_out_valid && !i_out_ready;
    assign in_take   = i_in_valid && o_in_ready;
    assign out_word  = {o_voice, o_duration, o_tone_high, o_tone_low, o_attenuation,
                        o_terminator, o_last};
    assign term_ok   = (o_duration == 16'hFFFF) && (o_tone_high == 6'd0)
                       && (o_tone_low == 4'd0) && (o_attenuation == 4'd0);

    `MEPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid, "output dropped")
    `MEPC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(out_word), "output moved")
    `MEPC_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_take, !o_in_ready, "input taken twice")
    `MEPC_ASSERT_NOW(a_term_shape, i_clk, i_rst_n, o_out_valid && o_terminator, term_ok, "bad end")
endmodule

bind midi_events_to_psg_commands_core mepc_chk u_chk (.*);

### tb/sv/midi_events_to_psg_commands_core_test.sv
// Self-checking testbench of the MIDI event to PSG command core.
// Depends on mepc_pkg and midi_events_to_psg_commands_core. A built-in predictor
// checks every output request, with random idling on both sides.
module midi_events_to_psg_commands_core_test;
    import mepc_pkg::*;

    localparam int N_CHANNELS = 16;
    localparam int N_VOICES = 4;
    localparam int NOISE_CH = 3;
    localparam logic [3:0] CMD_POLY_PRESS = 4'hA;
    localparam logic [3:0] CMD_PROGRAM = 4'hC;
    localparam logic [3:0] CMD_PITCH = 4'hE;
    localparam logic [7:0] CC_MODULATION = 8'h01;
    localparam logic [3:0] MAP_ADDR = 4'd0;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [1:0] voice;
        logic [15:0] duration;
        logic [5:0] tone_high;
        logic [3:0] tone_low;
        logic [3:0] attenuation;
        logic terminator;
        logic last;
    } t_psg_cmd;

    typedef struct {
        logic [7:0] dt;
        logic [7:0] ev;
        logic [7:0] p1;
        logic [7:0] p2;
        bit only_terms;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [7:0] i_delta_ticks = '0;
    logic [7:0] i_event_byte = '0;
    logic [7:0] i_param1 = '0;
    logic [7:0] i_param2 = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_voice;
    logic [15:0] o_duration;
    logic [5:0] o_tone_high;
    logic [3:0] o_tone_low;
    logic [3:0] o_attenuation;
    logic o_terminator;
    logic o_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    midi_events_to_psg_commands_core DUT (.*);

    // Predictor state: the channel map and everything the core tracks per channel and voice.
    logic [63:0] chan_map;
    logic [7:0] run_status;
    logic [31:0] tick_count;
    logic [7:0] note_held [N_CHANNELS];
    logic [15:0] voice_hz [N_VOICES];
    logic [31:0] period_start [N_VOICES];
    logic [15:0] borrow [N_VOICES];
    bit pend_ok [N_VOICES];
    t_psg_cmd pend [N_VOICES];

    // Commands still owed by the core, oldest first.
    t_psg_cmd cmd_fifo [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    // Appends one owed command behind all the others.
    function automatic void enqueue_cmd(input t_psg_cmd c);
        cmd_fifo = {cmd_fifo, c};
    endfunction

    // Note number to frequency: twelve-entry table of the top octave, shifted down
    // by octave; everything at or above the top octave saturates there.
    function automatic int unsigned note_freq(input logic [7:0] note);
        int s;
        int q;
        int sh;
        if (note == 8'd0) begin
            return 0;
        end
        s = int'(note) - 9;
        q = (s < 0) ? 0 : s / 12;
        sh = 10 - q;
        if (sh < 0) begin
            sh = 0;
        end
        return int'(TONE_TABLE[(int'(note) + 3) % 12]) >> sh;
    endfunction

    // The tone divider must fit ten bits, so low frequencies are raised by octaves.
    function automatic logic [9:0] tone_div(input longint f);
        longint d;
        d = 3579545 / (32 * f);
        while (d > 1023) begin
            f = f * 2;
            d = 3579545 / (32 * f);
        end
        return 10'(d);
    endfunction

    function automatic t_psg_cmd terminator_cmd(input int v);
        t_psg_cmd c;
        c = '{voice: 2'(v), duration: TERM_DURATION, tone_high: '0, tone_low: '0,
              attenuation: '0, terminator: 1'b1, last: 1'b0};
        return c;
    endfunction

    // A pending command leaves the voice; the noise voice always carries a fixed tone.
    task automatic emit_pending(input int v);
        t_psg_cmd c;
        c = pend[v];
        if (v == NOISE_CH) begin
            c.tone_high = NOISE_TONE_HIGH;
            c.tone_low = NOISE_TONE_LOW;
        end
        enqueue_cmd(c);
    endtask

    // A frequency change closes the period that the old frequency played.
    task automatic close_period(input int v, input int unsigned newf);
        longint t;
        logic [9:0] d;
        t_psg_cmd c;
        bit merge;
        if (newf == voice_hz[v]) begin
            return;
        end
        t = longint'(tick_count - period_start[v]) - longint'(borrow[v]);
        borrow[v] = '0;
        merge = 1'b0;
        if (t < 0) begin
            borrow[v] = 16'(-t);
            t = 0;
        end
        c.voice = 2'(v);
        c.duration = 16'(t);
        c.terminator = 1'b0;
        c.last = 1'b0;
        if (t == 0 && pend_ok[v]) begin
            if (voice_hz[v] != 0) begin
                // A note that lasted no time folds into the pending command.
                c.duration = pend[v].duration;
                merge = 1'b1;
            end else begin
                // Silence of no length still takes one tick, paid back later.
                c.duration = 16'd1;
                if (borrow[v] != BORROW_MAX) begin
                    borrow[v] = borrow[v] + 16'd1;
                end
            end
        end
        if (voice_hz[v] != 0) begin
            d = tone_div(longint'(voice_hz[v]));
            c.tone_high = d[9:4];
            c.tone_low = d[3:0];
            c.attenuation = (v == 0) ? ATT_VOICE0 : ((v == NOISE_CH) ? ATT_NOISE : ATT_TONE);
        end else begin
            c.tone_high = '0;
            c.tone_low = '0;
            c.attenuation = ATT_SILENT;
        end
        if (!merge && pend_ok[v]) begin
            emit_pending(v);
        end
        pend[v] = c;
        pend_ok[v] = 1'b1;
        voice_hz[v] = 16'(newf);
        period_start[v] = tick_count;
    endtask

    // Works out the commands that one accepted event causes and queues them.
    task automatic predict_event(input logic [7:0] dt, input logic [7:0] ev,
                                 input logic [7:0] p1, input logic [7:0] p2);
        int n0;
        int ch;
        int v;
        logic [3:0] op;
        n0 = cmd_fifo.size();
        if (dt != END_MARK) begin
            tick_count = tick_count + 32'(dt);
        end
        if (dt == END_MARK || ev == END_MARK) begin
            for (int i = 0; i < N_VOICES; i++) begin
                if (pend_ok[i]) begin
                    emit_pending(i);
                    pend_ok[i] = 1'b0;
                end
                enqueue_cmd(terminator_cmd(i));
            end
        end else begin
            if (ev < 8'h80) begin
                ev = run_status;
            end
            run_status = ev;
            op = ev[7:4];
            ch = int'(ev[3:0]);
            v = int'(chan_map[4 * ch +: 4]);
            if (v < N_VOICES) begin
                if (op == CMD_NOTE_ON && p2 != 8'd0) begin
                    close_period(v, note_freq(p1));
                    note_held[ch] = p1;
                end else if ((op == CMD_NOTE_ON || op == CMD_NOTE_OFF)
                             && note_held[ch] == p1) begin
                    // Note on with zero velocity counts as note off.
                    close_period(v, 0);
                    note_held[ch] = '0;
                end else if (op == CMD_CONTROL && (p1 == CC_NOTES_OFF || p1 == CC_SOUND_OFF)) begin
                    close_period(v, 0);
                end
            end
        end
        if (cmd_fifo.size() > n0) begin
            cmd_fifo[cmd_fifo.size() - 1].last = 1'b1;
        end
    endtask

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        errors++;
        if (errors <= 10) begin
            $display("Mismatch in %s: expected %h, got %h", what, want, got);
        end
    endfunction

    // Offers one event as an input request and predicts its commands once it is taken.
    // A row that expects only the four end markers gets them typed in directly.
    task automatic send_event(input logic [7:0] dt, input logic [7:0] ev,
                              input logic [7:0] p1, input logic [7:0] p2,
                              input bit only_terms);
        int n0;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_delta_ticks <= dt;
        i_event_byte <= ev;
        i_param1 <= p1;
        i_param2 <= p2;
        do @(posedge i_clk); while (!o_in_ready);
        n0 = cmd_fifo.size();
        predict_event(dt, ev, p1, p2);
        if (only_terms) begin
            while (cmd_fifo.size() > n0) begin
                cmd_fifo.delete(cmd_fifo.size() - 1);
            end
            for (int i = 0; i < N_VOICES; i++) begin
                enqueue_cmd(terminator_cmd(i));
            end
            cmd_fifo[cmd_fifo.size() - 1].last = 1'b1;
        end
    endtask

    // Waits until every owed command has come out, then lets a busy core finish
    // an event that produces nothing.
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cmd_fifo.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the channel map over the configuration port and reads it back.
    task automatic write_map(input logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAP_ADDR;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            report_mismatch("channel_map readback", value, prdata);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        chan_map = value;
    endtask

    function automatic logic [63:0] random_map;
        logic [63:0] m;
        int r;
        for (int c = 0; c < N_CHANNELS; c++) begin
            r = $urandom_range(5);
            m[4 * c +: 4] = (r >= 4) ? 4'(r == 4 ? 15 : $urandom_range(4, 15)) : 4'(r);
        end
        return m;
    endfunction

    // Random events: mostly well-formed note traffic with running status and
    // short deltas, plus some controllers, other commands, song ends and raw noise.
    task automatic send_random_event;
        logic [7:0] dt;
        logic [7:0] ev;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [3:0] ch;
        int r;
        int k;
        r = $urandom_range(99);
        dt = 8'($urandom);
        ev = 8'($urandom);
        p1 = 8'($urandom);
        p2 = 8'($urandom);
        if (r < 4) begin
            if ($urandom_range(1) == 0) begin
                dt = END_MARK;
            end else begin
                ev = END_MARK;
            end
        end else if (r >= 10) begin
            k = $urandom_range(99);
            dt = (k < 50) ? 8'd0 : ((k < 85) ? 8'($urandom_range(1, 8)) : dt);
            ch = 4'($urandom);
            k = $urandom_range(99);
            if (k < 45) begin
                ev = {CMD_NOTE_ON, ch};
                k = $urandom_range(99);
                p1 = (k < 50) ? 8'($urandom_range(55, 70)) : ((k < 60) ? 8'd0 : p1);
                p2 = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 127));
            end else if (k < 75) begin
                ev = {CMD_NOTE_OFF, ch};
                if ($urandom_range(3) != 0) begin
                    p1 = note_held[ch];
                end
            end else if (k < 87) begin
                ev = {CMD_CONTROL, ch};
                k = $urandom_range(2);
                p1 = (k == 0) ? CC_NOTES_OFF : ((k == 1) ? CC_SOUND_OFF : p1);
            end else begin
                k = $urandom_range(2);
                ev = {(k == 0) ? CMD_POLY_PRESS : ((k == 1) ? CMD_PROGRAM : CMD_PITCH), ch};
            end
            // Running status: repeat the last event byte with a data byte in its place.
            if (ev == run_status && $urandom_range(1) == 0) begin
                ev = 8'($urandom_range(127));
            end
        end
        send_event(dt, ev, p1, p2, 1'b0);
    endtask

    task automatic run_phase(input logic [63:0] map, input int idle_pct, input int stall_pct,
                             input int count);
        write_map(map);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_event();
        drain();
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every output request is checked against the oldest owed command.
    always @(posedge i_clk) begin : out_check
        t_psg_cmd want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cmd_fifo.size() == 0) begin
                report_mismatch("unexpected command, voice", 64'h0, 64'(o_voice));
            end else begin
                want = cmd_fifo.pop_front();
                if (o_voice !== want.voice)
                    report_mismatch("voice", 64'(want.voice), 64'(o_voice));
                if (o_duration !== want.duration)
                    report_mismatch("duration", 64'(want.duration), 64'(o_duration));
                if (o_tone_high !== want.tone_high)
                    report_mismatch("tone_high", 64'(want.tone_high), 64'(o_tone_high));
                if (o_tone_low !== want.tone_low)
                    report_mismatch("tone_low", 64'(want.tone_low), 64'(o_tone_low));
                if (o_attenuation !== want.attenuation)
                    report_mismatch("attenuation", 64'(want.attenuation), 64'(o_attenuation));
                if (o_terminator !== want.terminator)
                    report_mismatch("terminator", 64'(want.terminator), 64'(o_terminator));
                if (o_last !== want.last)
                    report_mismatch("last", 64'(want.last), 64'(o_last));
            end
        end
    end

    // The watchdog ends a run in which no request moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : main
        t_stim_row directed [22];
        chan_map = '1;
        run_status = '0;
        tick_count = '0;
        for (int i = 0; i < N_CHANNELS; i++) begin
            note_held[i] = '0;
        end
        for (int i = 0; i < N_VOICES; i++) begin
            voice_hz[i] = '0;
            period_start[i] = '0;
            borrow[i] = '0;
            pend_ok[i] = 1'b0;
        end

        // Channels 0 to 3 go to voices 0 to 3, the rest are unmapped.
        directed = '{
            '{END_MARK, 8'h00, 8'h00, 8'h00, 1'b1},              // end right after reset
            '{8'd0, {CMD_NOTE_ON, 4'd0}, 8'd60, 8'd100, 1'b0},
            '{8'd7, {CMD_NOTE_ON, 4'd0}, 8'd0, 8'd1, 1'b0},      // note 0 is silence
            '{8'd255, {CMD_NOTE_ON, 4'd1}, 8'd255, 8'd127, 1'b0}, // top note, longest delta
            '{8'd4, 8'h10, 8'd1, 8'd127, 1'b0},                  // running status, lowest note
            '{8'd0, {CMD_NOTE_OFF, 4'd1}, 8'd1, 8'd0, 1'b0},     // zero-length note merges
            '{8'd5, {CMD_NOTE_ON, 4'd2}, 8'd140, 8'd64, 1'b0},
            '{8'd0, {CMD_NOTE_ON, 4'd2}, 8'd9, 8'd64, 1'b0},
            '{8'd0, {CMD_NOTE_OFF, 4'd2}, 8'd9, 8'd0, 1'b0},
            '{8'd0, {CMD_NOTE_ON, 4'd2}, 8'd20, 8'd64, 1'b0},    // zero-length silence
            '{8'd3, {CMD_NOTE_ON, 4'd3}, 8'd69, 8'd80, 1'b0},    // noise voice
            '{8'd2, {CMD_CONTROL, 4'd3}, CC_NOTES_OFF, 8'd0, 1'b0},
            '{8'd1, {CMD_CONTROL, 4'd2}, CC_SOUND_OFF, 8'd0, 1'b0},
            '{8'd1, {CMD_CONTROL, 4'd0}, CC_MODULATION, 8'd5, 1'b0},
            '{8'd1, {CMD_NOTE_ON, 4'd0}, 8'd64, 8'd0, 1'b0},     // off for a note not held
            '{8'd1, {CMD_NOTE_ON, 4'd0}, 8'd0, 8'd0, 1'b0},
            '{8'd1, {CMD_POLY_PRESS, 4'd0}, 8'd60, 8'd60, 1'b0},
            '{8'd1, {CMD_PROGRAM, 4'd5}, 8'd60, 8'd60, 1'b0},    // unmapped channel
            '{8'd1, 8'h07, 8'd50, 8'd50, 1'b0},
            '{8'd0, END_MARK, 8'hFF, 8'hFF, 1'b0},
            '{END_MARK, END_MARK, 8'h00, 8'h00, 1'b0},
            '{8'd9, {CMD_PITCH, 4'd0}, 8'hFF, 8'hFF, 1'b0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The end marker row runs on the reset map, where every channel is unmapped.
        send_event(directed[0].dt, directed[0].ev, directed[0].p1, directed[0].p2,
                   directed[0].only_terms);
        drain();
        write_map(64'hFFFF_FFFF_FFFF_3210);
        for (int i = 1; i < 22; i++) begin
            send_event(directed[i].dt, directed[i].ev, directed[i].p1, directed[i].p2,
                       directed[i].only_terms);
        end
        drain();

        run_phase(64'h0, 0, 0, 97);
        run_phase(random_map(), 67, 0, 97);
        run_phase('1, 0, 0, 10);
        run_phase(64'h3210_3210_3210_3210, 0, 67, 97);
        run_phase(random_map(), 36, 36, 97);

        // The receiver holds off while events keep coming, so the core backs up.
        write_map(64'h3333_2222_1111_0000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_cycles = 400;
        repeat (40) send_random_event();
        drain();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
